// ----- rtl/core/smsd_pkg.sv -----
// Shared types and fixed field widths for the sample mean / std dev block.
// No dependencies.
package smsd_pkg;

    localparam int SAMPLE_W  = 16;  // width of the sample field
    localparam int MEAN_W    = 24;  // width of the mean field
    localparam int SD_W      = 24;  // width of the std dev field
    localparam int NCOUNT_W  = 9;   // width of the sample count field

    typedef struct packed {
        logic [MEAN_W-1:0]   mean_q8;
        logic [SD_W-1:0]     stddev_q8;
        logic [NCOUNT_W-1:0] sample_count;
        logic                overflowed;
    } smsd_result_t;

endpackage

// ----- rtl/core/smsd_calc.sv -----
// Sequencer for the end-of-set arithmetic: shift-add products, restoring
// divides and bitwise square root, all on one shared add/subtract unit.
// Depends on smsd_pkg.
module smsd_calc
    import smsd_pkg::*;
#(
    parameter int MAX_COUNT   = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            start,
    input  logic signed [SAMPLE_BITS+$clog2(MAX_COUNT):0]   start_sum,
    input  logic [2*SAMPLE_BITS+$clog2(MAX_COUNT)-1:0]      start_sq,
    input  logic [$clog2(MAX_COUNT+1)-1:0]                  start_n,
    input  logic                                            start_drop,
    output logic                                            busy,
    output logic                                            res_valid,
    input  logic                                            res_ready,
    output smsd_result_t                                    result
);

    localparam int CNT_W  = $clog2(MAX_COUNT + 1);
    localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_COUNT) + 1;
    localparam int SQ_W   = 2 * SAMPLE_BITS + $clog2(MAX_COUNT);
    localparam int NN_W   = 2 * CNT_W;
    localparam int D_W    = CNT_W + SQ_W;
    localparam int DS_W   = D_W + 2 * FRAC_BITS;
    localparam int Q_W    = SUM_W + FRAC_BITS;
    localparam int SQ_IT  = (DS_W + 1) / 2;
    localparam int AW     = DS_W + 1;
    localparam int ITER_W = $clog2(AW + 1);
    localparam logic [AW-1:0] ONE_INIT = AW'(1) << (2 * (SQ_IT - 1));

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MNN   = 8'b0000_0010,
        ST_MNSQ  = 8'b0000_0100,
        ST_MSS   = 8'b0000_1000,
        ST_DVAR  = 8'b0001_0000,
        ST_SQRT  = 8'b0010_0000,
        ST_DMEAN = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [ITER_W-1:0]   iter_reg, iter_next;
    logic [AW-1:0]       acc_reg, acc_next;
    logic [AW-1:0]       mcand_reg, mcand_next;
    logic [SUM_W-1:0]    mplier_reg, mplier_next;
    logic [AW-1:0]       one_reg, one_next;
    logic [NN_W-1:0]     dvs_reg, dvs_next;
    logic [SUM_W-1:0]    smag_reg, smag_next;
    logic [SQ_W-1:0]     sq_reg, sq_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                neg_reg, neg_next;
    logic                drop_reg, drop_next;
    logic [SD_W-1:0]     sd_reg, sd_next;
    logic [MEAN_W-1:0]   mean_reg, mean_next;

    // shared unit
    logic [AW-1:0]       alu_a, alu_b;
    logic                alu_sub;
    logic [AW:0]         alu_full;
    logic [AW-1:0]       alu_y;
    logic                alu_carry;

    logic [AW-1:0]       acc_step;
    logic [AW-1:0]       rem_sh;
    logic [AW-1:0]       quot_new;
    logic [AW-1:0]       res_new;
    logic [AW+23:0]      res_ext;
    logic [AW+23:0]      quot_ext;
    logic [CNT_W+8:0]    n_ext;
    logic                last_iter;

    always_comb begin
        alu_a   = acc_reg;
        alu_b   = mcand_reg;
        alu_sub = 1'b0;
        case (state_reg)
            ST_MSS: begin
                alu_sub = 1'b1;
            end
            ST_DVAR: begin
                alu_a   = rem_sh;
                alu_b   = AW'(dvs_reg);
                alu_sub = 1'b1;
            end
            ST_DMEAN: begin
                alu_a   = rem_sh;
                alu_b   = AW'(n_reg);
                alu_sub = 1'b1;
            end
            ST_SQRT: begin
                alu_b   = mcand_reg | one_reg;
                alu_sub = 1'b1;
            end
            default: begin
                alu_sub = 1'b0;
            end
        endcase
    end

    assign rem_sh    = {acc_reg[AW-2:0], mcand_reg[AW-1]};
    assign alu_full  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{AW{1'b0}}, alu_sub};
    assign alu_y     = alu_full[AW-1:0];
    assign alu_carry = alu_full[AW];

    assign acc_step  = mplier_reg[0] ? alu_y : acc_reg;
    assign quot_new  = {mcand_reg[AW-2:0], alu_carry};
    assign res_new   = alu_carry ? ((mcand_reg >> 1) | one_reg) : (mcand_reg >> 1);
    assign res_ext   = {24'd0, res_new};
    assign quot_ext  = {24'd0, quot_new};
    assign n_ext     = {9'd0, n_reg};
    assign last_iter = (iter_reg == '0);

    always_comb begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        one_next    = one_reg;
        dvs_next    = dvs_reg;
        smag_next   = smag_reg;
        sq_next     = sq_reg;
        n_next      = n_reg;
        neg_next    = neg_reg;
        drop_next   = drop_reg;
        sd_next     = sd_reg;
        mean_next   = mean_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    neg_next    = start_sum[SUM_W-1];
                    smag_next   = start_sum[SUM_W-1] ? SUM_W'(-start_sum)
                                                     : SUM_W'(start_sum);
                    sq_next     = start_sq;
                    n_next      = start_n;
                    drop_next   = start_drop;
                    acc_next    = '0;
                    mcand_next  = AW'(start_n);
                    mplier_next = SUM_W'(start_n);
                    iter_next   = ITER_W'(CNT_W - 1);
                    state_next  = ST_MNN;
                end
            end
            ST_MNN: begin
                // n * n into the accumulator, kept as the variance divisor
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                iter_next   = iter_reg - 1'b1;
                if (last_iter) begin
                    dvs_next    = acc_step[NN_W-1:0];
                    acc_next    = '0;
                    mcand_next  = AW'(sq_reg);
                    mplier_next = SUM_W'(n_reg);
                    iter_next   = ITER_W'(CNT_W - 1);
                    state_next  = ST_MNSQ;
                end
            end
            ST_MNSQ: begin
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                iter_next   = iter_reg - 1'b1;
                if (last_iter) begin
                    mcand_next  = AW'(smag_reg);
                    mplier_next = smag_reg;
                    iter_next   = ITER_W'(SUM_W - 1);
                    state_next  = ST_MSS;
                end
            end
            ST_MSS: begin
                // subtract sum^2 to leave D = n*sq - sum^2, never negative
                acc_next    = acc_step;
                mcand_next  = mcand_reg << 1;
                mplier_next = mplier_reg >> 1;
                iter_next   = iter_reg - 1'b1;
                if (last_iter) begin
                    mcand_next = acc_step << (AW - D_W);
                    acc_next   = '0;
                    iter_next  = ITER_W'(DS_W - 1);
                    state_next = ST_DVAR;
                end
            end
            ST_DVAR: begin
                acc_next   = alu_carry ? alu_y : rem_sh;
                mcand_next = quot_new;
                iter_next  = iter_reg - 1'b1;
                if (last_iter) begin
                    acc_next   = quot_new;
                    mcand_next = '0;
                    one_next   = ONE_INIT;
                    iter_next  = ITER_W'(SQ_IT - 1);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (alu_carry) begin
                    acc_next = alu_y;
                end
                mcand_next = res_new;
                one_next   = one_reg >> 2;
                iter_next  = iter_reg - 1'b1;
                if (last_iter) begin
                    sd_next    = res_ext[SD_W-1:0];
                    acc_next   = '0;
                    mcand_next = AW'(smag_reg) << (AW - SUM_W);
                    iter_next  = ITER_W'(Q_W - 1);
                    state_next = ST_DMEAN;
                end
            end
            ST_DMEAN: begin
                acc_next   = alu_carry ? alu_y : rem_sh;
                mcand_next = quot_new;
                iter_next  = iter_reg - 1'b1;
                if (last_iter) begin
                    mean_next  = neg_reg ? MEAN_W'(-quot_ext[MEAN_W-1:0])
                                         : quot_ext[MEAN_W-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        iter_reg   <= iter_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        one_reg    <= one_next;
        dvs_reg    <= dvs_next;
        smag_reg   <= smag_next;
        sq_reg     <= sq_next;
        n_reg      <= n_next;
        neg_reg    <= neg_next;
        drop_reg   <= drop_next;
        sd_reg     <= sd_next;
        mean_reg   <= mean_next;
    end

    assign busy                = (state_reg != ST_IDLE);
    assign res_valid           = (state_reg == ST_DONE);
    assign result.mean_q8      = mean_reg;
    assign result.stddev_q8    = sd_reg;
    assign result.sample_count = n_ext[NCOUNT_W-1:0];
    assign result.overflowed   = drop_reg;

endmodule

// ----- rtl/core/sample_mean_and_std_dev_top.sv -----
// Top level: accumulators and output register round smsd_calc; uses smsd_pkg.
// Samples other than a set's last are taken one per cycle while the sequencer is
// idle. A last-marked request starts the shared add/subtract sequencer: s_ready
// stays low until it has handed its result to the output register, longer while
// that register still holds an unread result; m_valid rises as it ends.
// Synchronous active-low reset clears accumulators, sequencer and output valid.
module sample_mean_and_std_dev_top
    import smsd_pkg::*;
#(
    parameter int MAX_COUNT   = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [SAMPLE_W-1:0]  s_sample,
    input  logic                        s_last,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [MEAN_W-1:0]    m_mean_q8,
    output logic [SD_W-1:0]             m_stddev_q8,
    output logic [NCOUNT_W-1:0]         m_sample_count,
    output logic                        m_overflowed
);

    // Accumulator widths: the sum and sum of squares never wrap within
    // MAX_COUNT samples, so the end-of-set arithmetic is exact.
    localparam int CNT_W = $clog2(MAX_COUNT + 1);
    localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_COUNT) + 1;
    localparam int SQ_W  = 2 * SAMPLE_BITS + $clog2(MAX_COUNT);

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SQ_W-1:0]         sq_reg, sq_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    drop_reg, drop_next;

    logic                    out_valid_reg, out_valid_next;
    smsd_result_t            out_res_reg, out_res_next;

    logic [SAMPLE_W+23:0]    in_ext;
    logic [SAMPLE_BITS-1:0]  samp_bits;
    logic [SAMPLE_BITS-1:0]  samp_mag;
    logic [2*SAMPLE_BITS-1:0] samp_sq;
    logic signed [SUM_W-1:0] samp_sum;
    logic                    in_accept;
    logic                    calc_start;
    logic                    calc_busy;
    logic                    calc_valid;
    logic                    calc_ready;
    smsd_result_t            calc_res;

    // Only the low SAMPLE_BITS of the sample take part; a wider setting than
    // the port simply sees zeros above bit 15.
    assign in_ext    = {24'd0, s_sample};
    assign samp_bits = in_ext[SAMPLE_BITS-1:0];
    assign samp_sum  = SUM_W'($signed(samp_bits));
    assign samp_mag  = samp_bits[SAMPLE_BITS-1] ? SAMPLE_BITS'(-samp_bits) : samp_bits;
    assign samp_sq   = samp_mag * samp_mag;

    // The sequencer owns the end-of-set work; no request is taken meanwhile.
    assign s_ready    = !calc_busy;
    assign in_accept  = s_valid && s_ready;
    assign calc_start = in_accept && s_last;

    always_comb begin
        sum_next  = sum_reg;
        sq_next   = sq_reg;
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (in_accept) begin
            if (cnt_reg < CNT_W'(MAX_COUNT)) begin
                sum_next = sum_reg + samp_sum;
                sq_next  = sq_reg + SQ_W'(samp_sq);
                cnt_next = cnt_reg + 1'b1;
            end else begin
                // full set: sample dropped, flagged in the result
                drop_next = 1'b1;
            end
        end
    end

    // Running totals, including the last sample, go to the sequencer; the
    // accumulators then clear for the next set.
    smsd_calc #(
        .MAX_COUNT   (MAX_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_calc (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (calc_start),
        .start_sum  (sum_next),
        .start_sq   (sq_next),
        .start_n    (cnt_next),
        .start_drop (drop_next),
        .busy       (calc_busy),
        .res_valid  (calc_valid),
        .res_ready  (calc_ready),
        .result     (calc_res)
    );

    // Output register: free, or emptied in this very cycle.
    assign calc_ready = !out_valid_reg || m_ready;

    always_comb begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (calc_valid && calc_ready) begin
            out_valid_next = 1'b1;
            out_res_next   = calc_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            sq_reg        <= '0;
            cnt_reg       <= '0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (calc_start) begin
                sum_reg  <= '0;
                sq_reg   <= '0;
                cnt_reg  <= '0;
                drop_reg <= 1'b0;
            end else begin
                sum_reg  <= sum_next;
                sq_reg   <= sq_next;
                cnt_reg  <= cnt_next;
                drop_reg <= drop_next;
            end
            out_valid_reg <= out_valid_next;
        end
        out_res_reg <= out_res_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_mean_q8      = out_res_reg.mean_q8;
    assign m_stddev_q8    = out_res_reg.stddev_q8;
    assign m_sample_count = out_res_reg.sample_count;
    assign m_overflowed   = out_res_reg.overflowed;

endmodule
